[hw/rtl/goc_pkg.sv]
// Shared types and constants for the grid obstacle clearance block.
`default_nettype none
package goc_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DIST_BITS  = 32;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = $clog2(CELLS);
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam logic [DIST_BITS-1:0] DIST_INF = '1;
    localparam logic [63:0] SQRT2_Q46 = 64'h5A827999FCEF;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CELL   = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,  // write one flag
        OP_READ  = 3'd2,  // read one distance
        OP_CELL  = 3'd3,  // one raster cell, read phase
        OP_STORE = 3'd4   // one raster cell, write back
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic                 backward;
        logic [XW-1:0]        x;
        logic [YW-1:0]        y;
        logic [ADDR_BITS-1:0] addr;
        logic                 obstacle;
    } t_cmd;

    typedef struct packed {
        logic [XW:0] w;
        logic [YW:0] h;
    } t_dims;

    function automatic logic [DIST_BITS-1:0] sat_add(
        input logic [DIST_BITS-1:0] a, input logic [DIST_BITS-1:0] b);
        logic [DIST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (a == DIST_INF || s[DIST_BITS] || s[DIST_BITS-1:0] == DIST_INF)
            return DIST_INF;
        return s[DIST_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

[hw/rtl/goc_datapath.sv]
// Datapath: obstacle map, distance store, neighbor relaxation.
`default_nettype none
module goc_datapath (
    input  wire logic                          i_clk,
    input  wire goc_pkg::t_cmd                 i_cmd,
    input  wire goc_pkg::t_dims                i_dims,
    input  wire logic [15:0]                   i_cell_size,
    input  wire logic [1:0]                    i_nb_sel,
    output logic [goc_pkg::DIST_BITS-1:0]      o_rd_data
);
    localparam int AB = goc_pkg::ADDR_BITS;
    localparam int DB = goc_pkg::DIST_BITS;

    logic          r_obst [goc_pkg::CELLS];
    logic [DB-1:0] r_dist [goc_pkg::CELLS];
    logic [DB-1:0] r_rd;
    logic [DB-1:0] r_best;
    logic [DB-1:0] r_diag;
    logic [DB-1:0] r_nb_cost;
    logic          r_nb_ok;

    // diagonal cost: one 16x47 product, registered
    logic [63:0] diag_prod;
    assign diag_prod = {48'd0, i_cell_size} * goc_pkg::SQRT2_Q46 + (64'd1 << 45);
    always_ff @(posedge i_clk) begin
        r_diag <= DB'(diag_prod >> 46);
    end

    // neighbor address for step i_nb_sel of this cell
    logic [AB-1:0] nb_addr;
    logic          nb_ok;
    logic          nb_diag;
    logic [AB:0]   w_ext;
    logic          last_x;
    logic          last_y;
    always_comb begin
        w_ext   = (AB+1)'(i_dims.w);
        last_x  = ({1'b0, i_cmd.x} + 1'b1) >= i_dims.w;
        last_y  = ({1'b0, i_cmd.y} + 1'b1) >= i_dims.h;
        nb_diag = 1'b0;
        nb_ok   = 1'b0;
        nb_addr = i_cmd.addr;
        if (!i_cmd.backward) begin
            unique case (i_nb_sel)
                2'd0: begin nb_ok = i_cmd.x != 0; nb_addr = i_cmd.addr - 1'b1; end
                2'd1: begin nb_ok = i_cmd.y != 0; nb_addr = i_cmd.addr - w_ext[AB-1:0]; end
                2'd2: begin
                    nb_ok = i_cmd.y != 0 && i_cmd.x != 0; nb_diag = 1'b1;
                    nb_addr = i_cmd.addr - w_ext[AB-1:0] - 1'b1;
                end
                default: begin
                    nb_ok = i_cmd.y != 0 && !last_x; nb_diag = 1'b1;
                    nb_addr = i_cmd.addr - w_ext[AB-1:0] + 1'b1;
                end
            endcase
        end else begin
            unique case (i_nb_sel)
                2'd0: begin nb_ok = !last_x; nb_addr = i_cmd.addr + 1'b1; end
                2'd1: begin nb_ok = !last_y; nb_addr = i_cmd.addr + w_ext[AB-1:0]; end
                2'd2: begin
                    nb_ok = !last_y && !last_x; nb_diag = 1'b1;
                    nb_addr = i_cmd.addr + w_ext[AB-1:0] + 1'b1;
                end
                default: begin
                    nb_ok = !last_y && i_cmd.x != 0; nb_diag = 1'b1;
                    nb_addr = i_cmd.addr + w_ext[AB-1:0] - 1'b1;
                end
            endcase
        end
    end

    logic [AB-1:0] rd_addr;
    assign rd_addr = (i_cmd.op == goc_pkg::OP_CELL) ? nb_addr : i_cmd.addr;

    // memories: obstacle map written by loads, distance store by write backs; reads at rd_addr and the cell address
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == goc_pkg::OP_LOAD) r_obst[i_cmd.addr] <= i_cmd.obstacle;
        if (i_cmd.op == goc_pkg::OP_STORE) r_dist[i_cmd.addr] <= r_best;
        r_rd <= r_dist[rd_addr];
    end

    // relaxation: own value seeded first, neighbors folded in one per cycle
    logic [DB-1:0] cand;
    logic          first_nb;
    assign cand = goc_pkg::sat_add(r_rd, r_nb_cost);
    assign first_nb = (i_cmd.op == goc_pkg::OP_CELL) && i_nb_sel == 2'd0;
    always_ff @(posedge i_clk) begin
        r_nb_ok     <= (i_cmd.op == goc_pkg::OP_CELL) && nb_ok;
        r_nb_cost   <= nb_diag ? r_diag : DB'(i_cell_size);
        if (first_nb) begin
            if (!i_cmd.backward)
                r_best <= r_obst[i_cmd.addr] ? '0 : goc_pkg::DIST_INF;
            else
                r_best <= r_dist[i_cmd.addr];
        end
        if (r_nb_ok && cand < (first_nb ? goc_pkg::DIST_INF : r_best) && !first_nb)
            r_best <= cand;
    end

    assign o_rd_data = r_rd;
endmodule
`default_nettype wire

[hw/rtl/goc_ctrl.sv]
// Controller: handshakes, raster sequencing and result register.
`default_nettype none
module goc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic [15:0]        i_cell_index,
    input  wire logic               i_is_obstacle,
    input  wire logic               i_last_cell,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [15:0]        i_cfg_data,
    output goc_pkg::t_cmd           o_cmd,
    output goc_pkg::t_dims          o_dims,
    output logic [15:0]             o_cell_size,
    output logic [1:0]              o_nb_sel,
    input  wire logic [31:0]        i_rd_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [31:0]             o_clearance
);
    localparam int XW = goc_pkg::XW;
    localparam int YW = goc_pkg::YW;
    localparam int AB = goc_pkg::ADDR_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD1   = 6'b000010,
        S_RD2   = 6'b000100,
        S_NB    = 6'b001000,
        S_WB    = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [8:0]    r_w9, r_h9;
    logic [15:0]   r_cs;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [AB-1:0] r_addr;
    logic          r_bwd;
    logic [2:0]    r_step;
    logic          r_ovld;
    logic [31:0]   r_out;
    logic          r_oor;

    // used dimensions: 0 acts as 1, clamp at maximum
    goc_pkg::t_dims dims;
    always_comb begin
        dims.w = (r_w9 == 0) ? (XW+1)'(1) :
                 (r_w9 > 9'(goc_pkg::MAX_WIDTH)) ? (XW+1)'(goc_pkg::MAX_WIDTH) : (XW+1)'(r_w9);
        dims.h = (r_h9 == 0) ? (YW+1)'(1) :
                 (r_h9 > 9'(goc_pkg::MAX_HEIGHT)) ? (YW+1)'(goc_pkg::MAX_HEIGHT) : (YW+1)'(r_h9);
    end
    logic [AB:0] count;
    assign count = (AB+1)'(dims.w) * (AB+1)'(dims.h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w9 <= 9'd256; r_h9 <= 9'd256; r_cs <= 16'd410;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                goc_pkg::REG_WIDTH:  r_w9 <= i_cfg_data[8:0];
                goc_pkg::REG_HEIGHT: r_h9 <= i_cfg_data[8:0];
                goc_pkg::REG_CELL:   r_cs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic accept, in_range, out_free, last_x, last_y, first_x, first_y;
    assign out_free = !r_ovld || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign in_range = {1'b0, i_cell_index} < count;
    assign last_x   = ({1'b0, r_x} + 1'b1) >= dims.w;
    assign last_y   = ({1'b0, r_y} + 1'b1) >= dims.h;
    assign first_x  = r_x == 0;
    assign first_y  = r_y == 0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:
                if (accept) begin
                    if (i_kind == goc_pkg::KIND_READ) n_state = S_RD1;
                    else if (i_last_cell) n_state = S_NB;
                end
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_IDLE;
            S_NB:    if (r_step == 3'd3) n_state = S_DRAIN;
            S_DRAIN: n_state = S_WB;
            S_WB: begin
                if (r_bwd && first_x && first_y) n_state = S_IDLE;
                else n_state = S_NB;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovld <= 1'b0;
            r_x <= '0; r_y <= '0; r_addr <= '0; r_bwd <= 1'b0; r_step <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovld && i_ready) r_ovld <= 1'b0;
            if (r_state == S_RD2) r_ovld <= 1'b1;
            if (r_state == S_IDLE && accept) begin
                r_addr <= (i_kind == goc_pkg::KIND_LOAD && i_last_cell) ? '0
                                                                        : AB'(i_cell_index);
                r_x <= '0; r_y <= '0; r_bwd <= 1'b0; r_step <= '0;
            end
            if (r_state == S_NB) r_step <= r_step + 1'b1;
            if (r_state == S_WB) begin
                r_step <= '0;
                if (!r_bwd) begin
                    if (last_x && last_y) r_bwd <= 1'b1;
                    else if (last_x) begin
                        r_x <= '0; r_y <= r_y + 1'b1; r_addr <= r_addr + 1'b1;
                    end else begin
                        r_x <= r_x + 1'b1; r_addr <= r_addr + 1'b1;
                    end
                end else if (!(first_x && first_y)) begin
                    r_addr <= r_addr - 1'b1;
                    if (first_x) begin
                        r_x <= XW'(dims.w - 1'b1); r_y <= r_y - 1'b1;
                    end else r_x <= r_x - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) r_oor <= !in_range;
        if (r_state == S_RD2)
            r_out <= (r_oor || i_rd_data == goc_pkg::DIST_INF) ? '1 : i_rd_data;
    end

    always_comb begin
        o_cmd.op       = goc_pkg::OP_NONE;
        o_cmd.backward = r_bwd;
        o_cmd.x        = r_x;
        o_cmd.y        = r_y;
        o_cmd.addr     = r_addr;
        o_cmd.obstacle = i_is_obstacle;
        if (r_state == S_IDLE && accept) begin
            o_cmd.addr = AB'(i_cell_index);
            if (i_kind == goc_pkg::KIND_LOAD && in_range) o_cmd.op = goc_pkg::OP_LOAD;
        end
        if (r_state == S_RD1) o_cmd.op = goc_pkg::OP_READ;
        if (r_state == S_NB) o_cmd.op = goc_pkg::OP_CELL;
        if (r_state == S_WB) o_cmd.op = goc_pkg::OP_STORE;
    end

    assign o_nb_sel    = r_step[1:0];
    assign o_dims      = dims;
    assign o_cell_size = r_cs;
    assign o_valid     = r_ovld;
    assign o_clearance = r_out;
endmodule
`default_nettype wire

[hw/rtl/grid_obstacle_clearance.sv]
// Top level: 8-neighbor chamfer clearance over a loaded occupancy grid.
//  channel | direction | signals
//  in      | in        | i_valid/o_ready, i_kind, i_cell_index, i_is_obstacle, i_last_cell
//  out     | out       | o_valid/i_ready, o_clearance
//  cfg     | in        | i_cfg_we, i_cfg_addr, i_cfg_data
// Loads write on acceptance; reads pass states RD1 and RD2 to the output register.
// The last load runs two raster passes; each cell takes 4 neighbor reads of the
// distance store, a pipeline drain and a write back.
// Reset is synchronous and active low; it clears control and loads 256x256, cell size 410.
// Output stalls hold the result register; input is taken when idle and it is free.
`default_nettype none
module grid_obstacle_clearance (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_cell_index,
    input  wire logic        i_is_obstacle,
    input  wire logic        i_last_cell,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_clearance,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_data
);
    goc_pkg::t_cmd  cmd;
    goc_pkg::t_dims dims;
    logic [15:0]    cs;
    logic [1:0]     nb_sel;
    logic [31:0]    rd_data;

    goc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_cell_index,
        .i_is_obstacle, .i_last_cell, .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .o_cmd(cmd), .o_dims(dims), .o_cell_size(cs), .o_nb_sel(nb_sel),
        .i_rd_data(rd_data), .o_valid, .i_ready, .o_clearance
    );

    goc_datapath u_dp (
        .i_clk, .i_cmd(cmd), .i_dims(dims), .i_cell_size(cs),
        .i_nb_sel(nb_sel), .o_rd_data(rd_data)
    );
endmodule
`default_nettype wire

[hw/rtl/goc_checker.sv]
// Port-level checker bound to the top level.
`default_nettype none
module goc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_kind,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_clearance
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_clearance)) else $error("result dropped");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_kind == 1'b0 && !o_valid |=> !o_valid)
        else $error("load produced result");
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_kind == 1'b1 |=> !o_ready) else $error("ready during read");
endmodule

bind grid_obstacle_clearance goc_checker u_goc_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .o_valid, .i_ready, .o_clearance
);
`default_nettype wire

[verif/tb_grid_obstacle_clearance.sv]
// Testbench for grid_obstacle_clearance: directed table, then random grids checked by a predictor.
`timescale 1ns / 1ps
module tb_grid_obstacle_clearance;
    localparam longint unsigned INF64 = 64'hFFFF_FFFF;

    typedef struct {
        logic        kind;
        logic [15:0] idx;
        logic        obs;
        logic        last;
        bit          typed;
        logic [31:0] val;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_kind = 0;
    logic [15:0] i_cell_index = 0;
    logic        i_is_obstacle = 0;
    logic        i_last_cell = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [31:0] o_clearance;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_addr = 0;
    logic [15:0] i_cfg_data = 0;

    grid_obstacle_clearance DUT (.*);

    always #5 i_clk = ~i_clk;

    // local copy of the block state
    bit              obst_map [goc_pkg::CELLS];
    bit              flag_loaded [goc_pkg::CELLS];
    bit              dist_valid [goc_pkg::CELLS];
    longint unsigned dist_store [goc_pkg::CELLS];
    int              cur_w = 256, cur_h = 256;
    longint unsigned cur_cell = 410;

    logic [31:0] clearance_q [$];
    int          n_mismatch = 0;
    int          n_items = 0;
    int          idle_tx = 9, idle_rx = 9;

    always @(posedge i_clk) i_ready <= ($urandom_range(99) >= idle_rx);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (clearance_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected clearance %h", o_clearance);
            end else begin
                if (o_clearance !== clearance_q[0]) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("clearance mismatch: expected %h, got %h",
                                 clearance_q[0], o_clearance);
                end
                void'(clearance_q.pop_front());
            end
        end
    end

    function automatic longint unsigned relaxed(longint unsigned cur, int nb,
                                                longint unsigned cost);
        longint unsigned a, cand;
        a = dist_store[nb];
        if (a >= INF64 || cost >= INF64 - a) cand = INF64;
        else cand = a + cost;
        return (cand < cur) ? cand : cur;
    endfunction

    task automatic compute_clearance();
        logic [63:0]     prod;
        longint unsigned diag, d;
        int              i;
        prod = cur_cell * goc_pkg::SQRT2_Q46 + (64'd1 << 45);
        diag = prod >> 46;
        for (int y = 0; y < cur_h; y++) begin
            for (int x = 0; x < cur_w; x++) begin
                i = y * cur_w + x;
                d = obst_map[i] ? 0 : INF64;
                if (x > 0) d = relaxed(d, i - 1, cur_cell);
                if (y > 0) begin
                    d = relaxed(d, i - cur_w, cur_cell);
                    if (x > 0) d = relaxed(d, i - cur_w - 1, diag);
                    if (x + 1 < cur_w) d = relaxed(d, i - cur_w + 1, diag);
                end
                dist_store[i] = d;
            end
        end
        for (int y = cur_h - 1; y >= 0; y--) begin
            for (int x = cur_w - 1; x >= 0; x--) begin
                i = y * cur_w + x;
                d = dist_store[i];
                if (x + 1 < cur_w) d = relaxed(d, i + 1, cur_cell);
                if (y + 1 < cur_h) begin
                    d = relaxed(d, i + cur_w, cur_cell);
                    if (x + 1 < cur_w) d = relaxed(d, i + cur_w + 1, diag);
                    if (x > 0) d = relaxed(d, i + cur_w - 1, diag);
                end
                dist_store[i] = d;
                dist_valid[i] = 1;
            end
        end
    endtask

    // one input transfer; updates the local state on acceptance
    task automatic send(t_row r);
        int count;
        longint unsigned v;
        if ($urandom_range(99) < idle_tx) begin
            i_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_tx) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= r.kind;
        i_cell_index <= r.idx;
        i_is_obstacle <= r.obs;
        i_last_cell <= r.last;
        do @(posedge i_clk); while (!o_ready);
        n_items++;
        count = cur_w * cur_h;
        if (r.kind == goc_pkg::KIND_LOAD) begin
            if (r.idx < count) begin
                obst_map[r.idx] = r.obs;
                flag_loaded[r.idx] = 1;
            end
            if (r.last) compute_clearance();
        end else begin
            v = (r.idx < count) ? dist_store[r.idx] : INF64;
            if (v >= INF64) v = INF64;
            clearance_q.push_back(r.typed ? r.val : v[31:0]);
        end
    endtask

    // always moves past the current edge, so valid gets one assignment per step
    task automatic drain();
        i_valid <= 0;
        do @(posedge i_clk); while (clearance_q.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic configure(int w_raw, int h_raw, int cs);
        drain();
        // a final load may still be computing with no read behind it
        while (!o_ready) @(posedge i_clk);
        write_reg(goc_pkg::REG_WIDTH, 16'(w_raw));
        write_reg(goc_pkg::REG_HEIGHT, 16'(h_raw));
        write_reg(goc_pkg::REG_CELL, 16'(cs));
        cur_w = (w_raw == 0) ? 1 : (w_raw > goc_pkg::MAX_WIDTH) ? goc_pkg::MAX_WIDTH : w_raw;
        cur_h = (h_raw == 0) ? 1 : (h_raw > goc_pkg::MAX_HEIGHT) ? goc_pkg::MAX_HEIGHT : h_raw;
        cur_cell = cs;
    endtask

    function automatic t_row mk(logic kind, int idx, logic obs, logic last);
        t_row r;
        r.kind = kind;
        r.idx = 16'(idx);
        r.obs = obs;
        r.last = last;
        r.typed = 0;
        r.val = '0;
        return r;
    endfunction

    function automatic t_row mk_read(int idx, bit typed, logic [31:0] val);
        t_row r;
        r = mk(goc_pkg::KIND_READ, idx, 0, 0);
        r.typed = typed;
        r.val = val;
        return r;
    endfunction

    // a read that never touches an unwritten store entry
    function automatic t_row legal_read(bit in_range);
        int count, idx;
        count = cur_w * cur_h;
        idx = $urandom_range(count - 1);
        if (!in_range || !dist_valid[idx]) idx = $urandom_range(65535, count);
        return mk_read(idx, 0, '0);
    endfunction

    task automatic run_grid(int w_raw, int h_raw, int cs);
        int count, density, nreads;
        bit all_loaded;
        configure(w_raw, h_raw, cs);
        count = cur_w * cur_h;
        case ($urandom_range(3))
            0: density = 0;
            1: density = 5;
            2: density = 30;
            default: density = 90;
        endcase
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 8) begin
                if ($urandom_range(1)) send(legal_read($urandom_range(1)));
                else send(mk(goc_pkg::KIND_LOAD, $urandom_range(65535, count),
                             $urandom_range(1), 0));
            end
            send(mk(goc_pkg::KIND_LOAD, i, $urandom_range(99) < density, i == count - 1));
        end
        if ($urandom_range(1)) drain();
        nreads = $urandom_range(80, 30);
        for (int k = 0; k < nreads; k++) begin
            if ($urandom_range(99) < 6) begin
                // partial reload, sometimes restarting the computation
                all_loaded = 1;
                for (int c = 0; c < count; c++) if (!flag_loaded[c]) all_loaded = 0;
                send(mk(goc_pkg::KIND_LOAD, $urandom_range(count - 1), $urandom_range(1),
                        all_loaded && $urandom_range(1)));
            end
            send(legal_read($urandom_range(99) < 85));
        end
    endtask

    initial begin
        t_row dir [$];
        dir.push_back(mk_read(16'hFFFF, 1, '1));
        dir.push_back(mk(goc_pkg::KIND_LOAD, 0, 0, 0));
        dir.push_back(mk(goc_pkg::KIND_LOAD, 1, 0, 0));
        dir.push_back(mk(goc_pkg::KIND_LOAD, 2, 0, 1));
        dir.push_back(mk_read(0, 1, '1));
        dir.push_back(mk_read(1, 1, '1));
        dir.push_back(mk_read(2, 1, '1));
        dir.push_back(mk(goc_pkg::KIND_LOAD, 1, 1, 1));
        dir.push_back(mk_read(0, 1, 32'd65535));
        dir.push_back(mk_read(1, 1, 32'd0));
        dir.push_back(mk_read(2, 1, 32'd65535));
        dir.push_back(mk_read(3, 1, '1));
        dir.push_back(mk(goc_pkg::KIND_LOAD, 16'hFFFF, 1, 1));
        dir.push_back(mk_read(2, 0, '0));
        dir.push_back(mk(goc_pkg::KIND_LOAD, 0, 1, 0));
        dir.push_back(mk_read(0, 1, 32'd65535));
        dir.push_back(mk(goc_pkg::KIND_LOAD, 16'h8000, 0, 1));
        dir.push_back(mk_read(0, 1, 32'd0));
        dir.push_back(mk_read(2, 0, '0));
        dir.push_back(mk(goc_pkg::KIND_LOAD, 2, 1, 0));
        dir.push_back(mk(goc_pkg::KIND_LOAD, 7, 0, 1));
        dir.push_back(mk_read(1, 0, '0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        configure(3, 1, 65535);
        foreach (dir[k]) send(dir[k]);

        run_grid(0, 5, 1);
        idle_tx = 0;
        idle_rx = 0;
        run_grid(511, 1, 65535);
        run_grid(1, 511, 410);
        idle_tx = 9;
        idle_rx = 9;
        run_grid(16, 16, 4096);
        run_grid(256, 2, 1);
        run_grid(9, 0, 300);
        while (n_items < 1700)
            run_grid($urandom_range(24, 1), $urandom_range(12, 1), $urandom_range(65535, 1));

        drain();
        repeat (20) @(posedge i_clk);
        if (n_mismatch == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
